// ===== src/tvpc_pkg.sv =====
package tvpc_pkg;

	localparam int VERTEX_W = 11;
	localparam int COUNT_W = 20;
	localparam int RES_W = 30;

	localparam int DEF_MAX_VERTICES = 1024;
	localparam int DEF_MAX_EDGES = 4096;

	localparam logic [RES_W-1:0] MOD_A = 30'd1000000007;
	localparam logic [RES_W-1:0] MOD_B = 30'd1000000009;
	localparam logic [RES_W-1:0] BASE_A = 30'd29;
	localparam logic [RES_W-1:0] BASE_B = 30'd31;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 20'hFFFFF;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	typedef struct packed {
		logic                operation;
		logic [VERTEX_W-1:0] first_vertex;
		logic [VERTEX_W-1:0] second_vertex;
	} tvpc_in_t;

	typedef struct packed {
		logic [COUNT_W-1:0] pair_count;
		logic               edge_overflow;
	} tvpc_out_t;

	// One value for each of the two hash moduli.
	typedef struct packed {
		logic [RES_W-1:0] lane_a;
		logic [RES_W-1:0] lane_b;
	} tvpc_pair_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FE_RD,
		ST_FE_LD,
		ST_PV,
		ST_PV_W,
		ST_PU,
		ST_PU_W,
		ST_HRD,
		ST_ADD_WU,
		ST_ADD_WV,
		ST_FE_CMP,
		ST_PAIR,
		ST_PAIR_DR,
		ST_OUT
	} tvpc_state_t;

	typedef enum logic [2:0] {
		PW_IDLE,
		PW_SQ,
		PW_SQ_W,
		PW_MUL,
		PW_MUL_W,
		PW_FIN
	} tvpc_pw_state_t;

	// One step of an interleaved modular product: 2r + (bit ? a : 0), reduced.
	function automatic logic [RES_W-1:0] mm_step(input logic [RES_W-1:0] r,
		input logic [RES_W-1:0] a, input logic b, input logic [RES_W-1:0] m);
		logic [RES_W+1:0] t;
		logic [RES_W+1:0] m1;
		logic [RES_W+1:0] m2;
		t = {1'b0, r, 1'b0} + (b ? {2'b00, a} : '0);
		m1 = {2'b00, m};
		m2 = {1'b0, m, 1'b0};
		if (t >= m2) begin
			t = t - m2;
		end else if (t >= m1) begin
			t = t - m1;
		end
		return t[RES_W-1:0];
	endfunction

	function automatic logic [RES_W-1:0] mod_add(input logic [RES_W-1:0] a,
		input logic [RES_W-1:0] b, input logic [RES_W-1:0] m);
		logic [RES_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, m}) begin
			s = s - {1'b0, m};
		end
		return s[RES_W-1:0];
	endfunction

	function automatic logic [RES_W-1:0] mod_sub(input logic [RES_W-1:0] a,
		input logic [RES_W-1:0] b, input logic [RES_W-1:0] m);
		logic [RES_W-1:0] d;
		if (a >= b) begin
			d = a - b;
		end else begin
			d = a + m - b;
		end
		return d;
	endfunction

endpackage

// ===== src/tvpc_modmul.sv =====
module tvpc_modmul (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  tvpc_pkg::tvpc_pair_t op_x,
	input  tvpc_pkg::tvpc_pair_t op_y,
	output logic                done,
	output tvpc_pkg::tvpc_pair_t result
);
	import tvpc_pkg::*;

	localparam int CW = $clog2(RES_W);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	tvpc_pair_t    x_q;
	tvpc_pair_t    y_q;
	tvpc_pair_t    r_q;

	// Both lanes step through the multiplier bits from the top, one bit a cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(RES_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= op_x;
			y_q <= op_y;
			r_q <= '0;
		end else if (busy_q) begin
			r_q.lane_a <= mm_step(r_q.lane_a, x_q.lane_a, y_q.lane_a[RES_W-1], MOD_A);
			r_q.lane_b <= mm_step(r_q.lane_b, x_q.lane_b, y_q.lane_b[RES_W-1], MOD_B);
			y_q.lane_a <= {y_q.lane_a[RES_W-2:0], 1'b0};
			y_q.lane_b <= {y_q.lane_b[RES_W-2:0], 1'b0};
		end
	end

	assign done   = done_q;
	assign result = r_q;

endmodule

// ===== src/tvpc_powmod.sv =====
module tvpc_powmod (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tvpc_pkg::VERTEX_W-1:0] exponent,
	output logic                          done,
	output tvpc_pkg::tvpc_pair_t          result
);
	import tvpc_pkg::*;

	localparam int BW = $clog2(VERTEX_W);

	tvpc_pw_state_t      state_q;
	tvpc_pw_state_t      state_d;
	logic [VERTEX_W-1:0] exp_q;
	logic [BW-1:0]       bit_q;
	tvpc_pair_t          r_q;
	tvpc_pair_t          base;
	tvpc_pair_t          mm_y;
	tvpc_pair_t          mm_res;
	logic                mm_start;
	logic                mm_done;
	logic                bit_last;

	assign base.lane_a = BASE_A;
	assign base.lane_b = BASE_B;
	assign bit_last = (bit_q == '0);

	tvpc_modmul u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.op_x   (r_q),
		.op_y   (mm_y),
		.done   (mm_done),
		.result (mm_res)
	);

	// Left to right: square, then multiply by the base where the exponent bit is set.
	always_comb begin
		state_d = state_q;
		case (state_q)
			PW_IDLE: begin
				if (start) begin
					state_d = PW_SQ;
				end
			end
			PW_SQ: state_d = PW_SQ_W;
			PW_SQ_W: begin
				if (mm_done) begin
					if (exp_q[bit_q]) begin
						state_d = PW_MUL;
					end else if (bit_last) begin
						state_d = PW_FIN;
					end else begin
						state_d = PW_SQ;
					end
				end
			end
			PW_MUL: state_d = PW_MUL_W;
			PW_MUL_W: begin
				if (mm_done) begin
					state_d = bit_last ? PW_FIN : PW_SQ;
				end
			end
			PW_FIN: state_d = PW_IDLE;
			default: state_d = PW_IDLE;
		endcase
	end

	always_comb begin
		mm_start = (state_q == PW_SQ) || (state_q == PW_MUL);
		mm_y     = (state_q == PW_MUL) ? base : r_q;
		done     = (state_q == PW_FIN);
		result   = r_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PW_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == PW_IDLE && start) begin
			exp_q      <= exponent;
			bit_q      <= BW'(VERTEX_W - 1);
			r_q.lane_a <= RES_W'(1);
			r_q.lane_b <= RES_W'(1);
		end else if (state_q == PW_SQ_W && mm_done) begin
			r_q <= mm_res;
			if (!exp_q[bit_q] && !bit_last) begin
				bit_q <= bit_q - BW'(1);
			end
		end else if (state_q == PW_MUL_W && mm_done) begin
			r_q <= mm_res;
			if (!bit_last) begin
				bit_q <= bit_q - BW'(1);
			end
		end
	end

endmodule

// ===== src/twin_vertex_pair_counter_top.sv =====
// Twin vertex pair counter.
// Requests arrive on in_valid / in_data and the block holds them off with
// in_stall; an add request carries one undirected edge, a finish request asks
// for the count. Results leave on out_valid / out_data under out_stall; only a
// finish request produces a result. The user must write vertex_count through
// cfg_wr_en / cfg_wr_data only while the block is idle; no logic enforces it.
// An edge request takes two modular exponentiations on the shared dual-lane
// modular multiplier: an 11-bit exponent takes 11 squarings plus one product
// per set bit. Out-of-range edges, self-loops and dropped edges are taken
// without leaving the idle state. A finish request repeats both exponentiations
// for every stored edge to check it for a match, then, with at least two
// vertices, compares every vertex pair at one pair per cycle through the two
// read ports of the hash memory, and then sweeps the hash memory to zero. The
// block takes one request at a time. After reset the same clearing sweep runs
// before the first request is taken. A result waits in the output register
// while the receiver stalls; add requests are still taken, and a later finish
// waits for the register to empty.
module twin_vertex_pair_counter_top #(
	parameter int MAX_VERTICES = tvpc_pkg::DEF_MAX_VERTICES,
	parameter int MAX_EDGES    = tvpc_pkg::DEF_MAX_EDGES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  tvpc_pkg::tvpc_in_t            in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output tvpc_pkg::tvpc_out_t           out_data,
	input  logic                          cfg_wr_en,
	input  logic [tvpc_pkg::VERTEX_W-1:0] cfg_wr_data
);
	import tvpc_pkg::*;

	localparam int VW  = $clog2(MAX_VERTICES);
	localparam int NW  = ((VW > VERTEX_W) ? VW : VERTEX_W) + 1;
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ECW = $clog2(MAX_EDGES + 1);

	tvpc_state_t state_q;
	tvpc_state_t state_d;

	logic [VERTEX_W-1:0] vcount_q;
	logic [NW-1:0]       n_eff;
	logic [NW-1:0]       nm1_w;
	logic [NW-1:0]       nm2_w;
	logic [VW-1:0]       nm1;
	logic [VW-1:0]       nm2;
	logic                n_ge2;

	logic                accept;
	logic [NW-1:0]       u_w;
	logic [NW-1:0]       v_w;
	logic [NW-1:0]       u_idx_w;
	logic [NW-1:0]       v_idx_w;
	logic                edge_ok;
	logic                edge_full;

	logic                fin_q;
	logic [VW-1:0]       cur_u_q;
	logic [VW-1:0]       cur_v_q;
	tvpc_pair_t          pv_q;
	tvpc_pair_t          pu_q;
	logic [ECW-1:0]      edges_held_q;
	logic                overflow_q;
	logic [ECW-1:0]      k_q;
	logic [ECW-1:0]      k_next;
	logic [VW-1:0]       i_q;
	logic [VW-1:0]       j_q;
	logic                pair_last;
	logic [VW-1:0]       clr_q;
	logic                clr_last;
	logic [COUNT_W-1:0]  total_q;
	logic [COUNT_W-1:0]  total_inc;
	logic                cmp_v_s1;
	logic                edge_match;
	logic                out_valid_q;
	tvpc_out_t           out_data_q;
	logic                out_free;

	tvpc_pair_t          hash_mem [MAX_VERTICES];
	tvpc_pair_t          rd0_q;
	tvpc_pair_t          rd1_q;
	logic                hash_we;
	logic [VW-1:0]       hash_wa;
	tvpc_pair_t          hash_wd;
	logic [VW-1:0]       hash_ra0;
	logic [VW-1:0]       hash_ra1;

	logic [2*VW-1:0]     edge_mem [MAX_EDGES];
	logic [2*VW-1:0]     edge_rd_q;
	logic                edge_we;

	logic                pw_start;
	logic                pw_done;
	logic [VERTEX_W-1:0] pw_exp;
	logic [NW-1:0]       pw_exp_w;
	tvpc_pair_t          pw_res;

	// The number of vertices in use is the register value capped at the store depth.
	assign n_eff = (NW'(vcount_q) > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(vcount_q);
	assign nm1_w = n_eff - NW'(1);
	assign nm2_w = n_eff - NW'(2);
	assign nm1   = nm1_w[VW-1:0];
	assign nm2   = nm2_w[VW-1:0];
	assign n_ge2 = (n_eff >= NW'(2));

	// An edge counts only with both endpoints in 1..n and distinct.
	assign accept    = in_valid && (state_q == ST_IDLE);
	assign u_w       = NW'(in_data.first_vertex);
	assign v_w       = NW'(in_data.second_vertex);
	assign u_idx_w   = u_w - NW'(1);
	assign v_idx_w   = v_w - NW'(1);
	assign edge_ok   = (u_w != '0) && (v_w != '0) && (u_w <= n_eff) && (v_w <= n_eff)
		&& (u_w != v_w);
	assign edge_full = (edges_held_q >= ECW'(MAX_EDGES));

	assign k_next    = k_q + ECW'(1);
	assign pair_last = (j_q == nm1) && (i_q == nm2);
	assign clr_last  = (clr_q == VW'(MAX_VERTICES - 1));
	assign total_inc = (total_q == COUNT_MAX) ? total_q : total_q + COUNT_W'(1);
	assign out_free  = !out_valid_q || !out_stall;

	// An edge matches when both endpoints' sums agree once each has the other removed.
	assign edge_match =
		(mod_sub(rd0_q.lane_a, pv_q.lane_a, MOD_A) == mod_sub(rd1_q.lane_a, pu_q.lane_a, MOD_A))
		&& (mod_sub(rd0_q.lane_b, pv_q.lane_b, MOD_B)
		== mod_sub(rd1_q.lane_b, pu_q.lane_b, MOD_B));

	tvpc_powmod u_powmod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (pw_start),
		.exponent (pw_exp),
		.done     (pw_done),
		.result   (pw_res)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (in_data.operation == OP_FINISH) begin
						if (edges_held_q != '0) begin
							state_d = ST_FE_RD;
						end else begin
							state_d = n_ge2 ? ST_PAIR : ST_OUT;
						end
					end else if (edge_ok && !edge_full) begin
						state_d = ST_PV;
					end
				end
			end
			ST_FE_RD: state_d = ST_FE_LD;
			ST_FE_LD: state_d = ST_PV;
			ST_PV:    state_d = ST_PV_W;
			ST_PV_W: begin
				if (pw_done) begin
					state_d = ST_PU;
				end
			end
			ST_PU:    state_d = ST_PU_W;
			ST_PU_W: begin
				if (pw_done) begin
					state_d = ST_HRD;
				end
			end
			ST_HRD:    state_d = fin_q ? ST_FE_CMP : ST_ADD_WU;
			ST_ADD_WU: state_d = ST_ADD_WV;
			ST_ADD_WV: state_d = ST_IDLE;
			ST_FE_CMP: begin
				if (k_next == edges_held_q) begin
					state_d = n_ge2 ? ST_PAIR : ST_OUT;
				end else begin
					state_d = ST_FE_RD;
				end
			end
			ST_PAIR: begin
				if (pair_last) begin
					state_d = ST_PAIR_DR;
				end
			end
			ST_PAIR_DR: state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_CLEAR;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		in_stall = (state_q != ST_IDLE);
		pw_start = (state_q == ST_PV) || (state_q == ST_PU);
		pw_exp_w = NW'((state_q == ST_PV) ? cur_v_q : cur_u_q) + NW'(1);
		pw_exp   = pw_exp_w[VERTEX_W-1:0];
		hash_we  = 1'b0;
		hash_wa  = clr_q;
		hash_wd  = '0;
		hash_ra0 = (state_q == ST_PAIR) ? i_q : cur_u_q;
		hash_ra1 = (state_q == ST_PAIR) ? j_q : cur_v_q;
		edge_we  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				hash_we = 1'b1;
			end
			ST_ADD_WU: begin
				hash_we        = 1'b1;
				hash_wa        = cur_u_q;
				hash_wd.lane_a = mod_add(rd0_q.lane_a, pv_q.lane_a, MOD_A);
				hash_wd.lane_b = mod_add(rd0_q.lane_b, pv_q.lane_b, MOD_B);
			end
			ST_ADD_WV: begin
				hash_we        = 1'b1;
				hash_wa        = cur_v_q;
				hash_wd.lane_a = mod_add(rd1_q.lane_a, pu_q.lane_a, MOD_A);
				hash_wd.lane_b = mod_add(rd1_q.lane_b, pu_q.lane_b, MOD_B);
				edge_we        = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			vcount_q     <= VERTEX_W'(1);
			edges_held_q <= '0;
			overflow_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			cmp_v_s1     <= 1'b0;
		end else begin
			state_q  <= state_d;
			cmp_v_s1 <= (state_q == ST_PAIR);
			if (cfg_wr_en) begin
				vcount_q <= cfg_wr_data;
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_last ? '0 : clr_q + VW'(1);
			end
			if (accept && in_data.operation == OP_ADD && edge_ok && edge_full) begin
				overflow_q <= 1'b1;
			end
			if (state_q == ST_ADD_WV) begin
				edges_held_q <= edges_held_q + ECW'(1);
			end
			if (state_q == ST_OUT && out_free) begin
				out_valid_q  <= 1'b1;
				edges_held_q <= '0;
				overflow_q   <= 1'b0;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fin_q   <= (in_data.operation == OP_FINISH);
			cur_u_q <= u_idx_w[VW-1:0];
			cur_v_q <= v_idx_w[VW-1:0];
			k_q     <= '0;
			i_q     <= '0;
			j_q     <= VW'(1);
			total_q <= '0;
		end
		if (state_q == ST_FE_LD) begin
			cur_u_q <= edge_rd_q[2*VW-1:VW];
			cur_v_q <= edge_rd_q[VW-1:0];
		end
		if (state_q == ST_PV_W && pw_done) begin
			pv_q <= pw_res;
		end
		if (state_q == ST_PU_W && pw_done) begin
			pu_q <= pw_res;
		end
		if (state_q == ST_FE_CMP) begin
			k_q <= k_next;
			if (edge_match) begin
				total_q <= total_inc;
			end
		end
		if (state_q == ST_PAIR) begin
			if (j_q == nm1) begin
				i_q <= i_q + VW'(1);
				j_q <= i_q + VW'(2);
			end else begin
				j_q <= j_q + VW'(1);
			end
		end
		if (cmp_v_s1 && rd0_q == rd1_q) begin
			total_q <= total_inc;
		end
		if (state_q == ST_OUT && out_free) begin
			out_data_q.pair_count    <= total_q;
			out_data_q.edge_overflow <= overflow_q;
		end
	end

	// Hash sums: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (hash_we) begin
			hash_mem[hash_wa] <= hash_wd;
		end
		rd0_q <= hash_mem[hash_ra0];
		rd1_q <= hash_mem[hash_ra1];
	end

	// Stored edges as zero-based endpoint pairs.
	always_ff @(posedge clk) begin
		if (edge_we) begin
			edge_mem[edges_held_q[EAW-1:0]] <= {cur_u_q, cur_v_q};
		end
		edge_rd_q <= edge_mem[k_q[EAW-1:0]];
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import tvpc_pkg::*;

	// Number of vertices the block holds; the vertex count in use is capped here.
	localparam int NV_CAP = DEF_MAX_VERTICES;

	// Cycles the block may still be busy after a result: the hash memory sweep.
	localparam int SETTLE_CYCLES = 1500;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	tvpc_in_t   in_data;
	logic       out_valid;
	logic       out_stall;
	tvpc_out_t  out_data;
	logic       cfg_wr_en;
	logic [VERTEX_W-1:0] cfg_wr_data;

	twin_vertex_pair_counter_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Shadow copy of the block: per-vertex hash sums in both lanes, the stored
	// edges, the overflow flag and the vertex count register.
	logic [RES_W-1:0]    hsum_a [NV_CAP];
	logic [RES_W-1:0]    hsum_b [NV_CAP];
	logic [VERTEX_W-1:0] held_u [$];
	logic [VERTEX_W-1:0] held_v [$];
	logic                dropped_edge;
	logic [VERTEX_W-1:0] vertex_reg;

	// Counts still owed by the block, oldest first.
	tvpc_out_t pending_counts [$];

	int errors = 0;
	int requests_sent;
	int counts_seen = 0;
	int graphs_done;

	// Plain square-and-multiply; the operands fit in 64 bits after each product.
	function automatic logic [RES_W-1:0] pow_mod(input logic [RES_W-1:0] base,
		input logic [VERTEX_W-1:0] e, input logic [RES_W-1:0] m);
		longint unsigned r;
		longint unsigned x;
		logic [VERTEX_W-1:0] k;
		r = 1;
		x = 64'(base % m);
		k = e;
		while (k != 0) begin
			if (k[0]) begin
				r = (r * x) % m;
			end
			x = (x * x) % m;
			k = k >> 1;
		end
		return r[RES_W-1:0];
	endfunction

	function automatic logic [RES_W-1:0] add_mod(input logic [RES_W-1:0] a,
		input logic [RES_W-1:0] b, input logic [RES_W-1:0] m);
		longint unsigned s;
		s = (longint'(a) + longint'(b)) % m;
		return s[RES_W-1:0];
	endfunction

	function automatic logic [RES_W-1:0] sub_mod(input logic [RES_W-1:0] a,
		input logic [RES_W-1:0] b, input logic [RES_W-1:0] m);
		longint unsigned d;
		d = (a >= b) ? longint'(a) - longint'(b) : longint'(a) + longint'(m) - longint'(b);
		return d[RES_W-1:0];
	endfunction

	function automatic int active_vertices();
		return (vertex_reg > NV_CAP) ? NV_CAP : int'(vertex_reg);
	endfunction

	function automatic void wipe_graph();
		for (int i = 0; i < NV_CAP; i++) begin
			hsum_a[i] = '0;
			hsum_b[i] = '0;
		end
		held_u.delete();
		held_v.delete();
		dropped_edge = 1'b0;
	endfunction

	// Applies one accepted request to the shadow state. Returns 1 and the count
	// for a finish request, 0 for an edge.
	function automatic bit predict_twins(input tvpc_in_t req, output tvpc_out_t res);
		int n;
		int iu;
		int iv;
		longint unsigned total;
		logic [VERTEX_W-1:0] u;
		logic [VERTEX_W-1:0] v;
		n = active_vertices();
		res = '0;
		if (req.operation == OP_ADD) begin
			u = req.first_vertex;
			v = req.second_vertex;
			// Endpoints out of range and self-loops leave no trace at all.
			if (u == 0 || v == 0 || u > n || v > n || u == v) begin
				return 0;
			end
			if (held_u.size() >= DEF_MAX_EDGES) begin
				dropped_edge = 1'b1;
				return 0;
			end
			iu = int'(u) - 1;
			iv = int'(v) - 1;
			hsum_a[iu] = add_mod(hsum_a[iu], pow_mod(BASE_A, v, MOD_A), MOD_A);
			hsum_b[iu] = add_mod(hsum_b[iu], pow_mod(BASE_B, v, MOD_B), MOD_B);
			hsum_a[iv] = add_mod(hsum_a[iv], pow_mod(BASE_A, u, MOD_A), MOD_A);
			hsum_b[iv] = add_mod(hsum_b[iv], pow_mod(BASE_B, u, MOD_B), MOD_B);
			held_u = {held_u, u};
			held_v = {held_v, v};
			return 0;
		end
		total = 0;
		// An edge counts when its endpoints look alike once each drops the other.
		foreach (held_u[k]) begin
			u = held_u[k];
			v = held_v[k];
			iu = int'(u) - 1;
			iv = int'(v) - 1;
			if (sub_mod(hsum_a[iu], pow_mod(BASE_A, v, MOD_A), MOD_A) ==
				sub_mod(hsum_a[iv], pow_mod(BASE_A, u, MOD_A), MOD_A) &&
				sub_mod(hsum_b[iu], pow_mod(BASE_B, v, MOD_B), MOD_B) ==
				sub_mod(hsum_b[iv], pow_mod(BASE_B, u, MOD_B), MOD_B)) begin
				total++;
			end
		end
		for (int i = 0; i < n; i++) begin
			for (int j = i + 1; j < n; j++) begin
				if (hsum_a[i] == hsum_a[j] && hsum_b[i] == hsum_b[j]) begin
					total++;
				end
			end
		end
		res.pair_count = (total > COUNT_MAX) ? COUNT_MAX : total[COUNT_W-1:0];
		res.edge_overflow = dropped_edge;
		wipe_graph();
		return 1;
	endfunction

	// Mostly short gaps, now and then a long one, and runs with none at all.
	function automatic int pick_gap();
		int r;
		r = int'($urandom_range(0, 99));
		if (r < 55) begin
			return 0;
		end else if (r < 92) begin
			return int'($urandom_range(1, 4));
		end
		return int'($urandom_range(20, 120));
	endfunction

	// Sends one request and holds it until the block takes it. The sampled
	// in_stall after the edge is the value the block saw at that edge.
	// A typed expectation, when given, replaces the predicted count.
	task automatic send_request(input tvpc_in_t req, input bit typed,
		input logic [COUNT_W-1:0] typed_count);
		tvpc_out_t res;
		int gap;
		in_valid <= 1'b1;
		in_data <= req;
		do begin
			@(posedge clk);
		end while (in_stall);
		requests_sent++;
		if (predict_twins(req, res)) begin
			if (typed) begin
				res.pair_count = typed_count;
				res.edge_overflow = 1'b0;
			end
			pending_counts = {pending_counts, res};
		end
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// The register is only written once the block has gone quiet: every count
	// has come back and the clearing sweep after it has had time to finish.
	task automatic write_vertex_count(input logic [VERTEX_W-1:0] value);
		in_valid <= 1'b0;
		while (pending_counts.size() > 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		vertex_reg = value;
	endtask

	// The receiver stalls in bursts of random length.
	int stall_left;
	always @(posedge clk) begin
		if (!arst_n) begin
			stall_left <= 0;
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else begin
			stall_left <= pick_gap();
			out_stall <= 1'b0;
		end
	end

	// Every accepted result is matched against the oldest pending count.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			counts_seen++;
			if (pending_counts.size() == 0) begin
				if (errors < 10) begin
					$display("unexpected result: count %0d overflow %0b",
						out_data.pair_count, out_data.edge_overflow);
				end
				errors++;
			end else begin
				if (out_data.pair_count !== pending_counts[0].pair_count ||
					out_data.edge_overflow !== pending_counts[0].edge_overflow) begin
					if (errors < 10) begin
						$display("result %0d: count %0d overflow %0b, expected %0d / %0b",
							counts_seen, out_data.pair_count, out_data.edge_overflow,
							pending_counts[0].pair_count, pending_counts[0].edge_overflow);
					end
					errors++;
				end
				void'(pending_counts.pop_front());
			end
		end
	end

	// Directed table: configuration rows and request rows in one list.
	typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;
	typedef struct {
		row_kind_t           kind;
		logic                op;
		logic [VERTEX_W-1:0] a;
		logic [VERTEX_W-1:0] b;
		bit                  typed;
		logic [COUNT_W-1:0]  count;
	} plan_row_t;

	plan_row_t plan [$];

	function automatic void append_row(input row_kind_t kind, input logic op,
		input int a, input int b, input int typed, input int count);
		plan_row_t r;
		r.kind = kind;
		r.op = op;
		r.a = VERTEX_W'(a);
		r.b = VERTEX_W'(b);
		r.typed = (typed != 0);
		r.count = COUNT_W'(count);
		plan = {plan, r};
	endfunction

	initial begin
		tvpc_in_t req;
		int n;
		int edges;
		int u;
		int v;
		int largest_n;
		in_valid = 1'b0;
		in_data = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		requests_sent = 0;
		graphs_done = 0;
		largest_n = 0;
		vertex_reg = VERTEX_W'(1);
		wipe_graph();
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Straight after reset one vertex exists, so there are no pairs.
		append_row(ROW_REQ, OP_FINISH, 2047, 2047, 1, 0);
		// No vertices: every edge is out of range and the count is zero.
		append_row(ROW_CFG, OP_ADD, 0, 0, 0, 0);
		append_row(ROW_REQ, OP_ADD, 1, 2, 0, 0);
		append_row(ROW_REQ, OP_FINISH, 0, 0, 1, 0);
		// Two vertices joined by one edge: the edge itself matches, the pair not.
		append_row(ROW_CFG, OP_ADD, 2, 0, 0, 0);
		append_row(ROW_REQ, OP_ADD, 1, 2, 0, 0);
		append_row(ROW_REQ, OP_ADD, 2, 2, 0, 0);
		append_row(ROW_REQ, OP_ADD, 0, 1, 0, 0);
		append_row(ROW_REQ, OP_ADD, 1, 3, 0, 0);
		append_row(ROW_REQ, OP_FINISH, 0, 0, 1, 1);
		// A path of three: the two ends share a neighbor set.
		append_row(ROW_CFG, OP_ADD, 3, 0, 0, 0);
		append_row(ROW_REQ, OP_ADD, 1, 3, 0, 0);
		append_row(ROW_REQ, OP_ADD, 3, 2, 0, 0);
		append_row(ROW_REQ, OP_FINISH, 0, 0, 0, 0);
		// A triangle among four vertices.
		append_row(ROW_CFG, OP_ADD, 4, 0, 0, 0);
		append_row(ROW_REQ, OP_ADD, 1, 2, 0, 0);
		append_row(ROW_REQ, OP_ADD, 2, 3, 0, 0);
		append_row(ROW_REQ, OP_ADD, 3, 1, 0, 0);
		append_row(ROW_REQ, OP_FINISH, 5, 9, 0, 0);
		// Register at all ones saturates to the full vertex range; edges past it
		// are ignored, the top vertex is reachable.
		append_row(ROW_CFG, OP_ADD, 2047, 0, 0, 0);
		append_row(ROW_REQ, OP_ADD, 1, 1024, 0, 0);
		append_row(ROW_REQ, OP_ADD, 1024, 1025, 0, 0);
		append_row(ROW_REQ, OP_ADD, 2047, 1024, 0, 0);
		append_row(ROW_REQ, OP_FINISH, 1024, 1024, 0, 0);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				write_vertex_count(plan[i].a);
			end else begin
				req.operation = plan[i].op;
				req.first_vertex = plan[i].a;
				req.second_vertex = plan[i].b;
				send_request(req, plan[i].typed, plan[i].count);
			end
		end
		largest_n = NV_CAP;

		// Random graphs on few vertices, so that twins and matching edges turn
		// up often; a share of each graph is noise over the whole field width.
		// Filling the edge store takes far more edges than this run can afford,
		// so the overflow flag is only checked at zero here.
		while (requests_sent < 450) begin
			n = ($urandom_range(0, 9) == 0) ? int'($urandom_range(49, 160))
				: int'($urandom_range(2, 48));
			write_vertex_count(VERTEX_W'(n));
			edges = int'($urandom_range(1, 20));
			for (int k = 0; k < edges; k++) begin
				req.operation = OP_ADD;
				case ($urandom_range(0, 9))
					0: begin
						req.first_vertex = VERTEX_W'($urandom_range(0, 2047));
						req.second_vertex = VERTEX_W'($urandom_range(0, 2047));
					end
					1: begin
						u = int'($urandom_range(1, n));
						req.first_vertex = VERTEX_W'(u);
						req.second_vertex = VERTEX_W'(u);
					end
					default: begin
						u = int'($urandom_range(1, n));
						v = int'($urandom_range(1, n - 1));
						if (v >= u) begin
							v++;
						end
						req.first_vertex = VERTEX_W'(u);
						req.second_vertex = VERTEX_W'(v);
					end
				endcase
				send_request(req, 1'b0, '0);
			end
			// The vertex fields of a finish are ignored, so they carry noise.
			req.operation = OP_FINISH;
			req.first_vertex = VERTEX_W'($urandom_range(0, 2047));
			req.second_vertex = VERTEX_W'($urandom_range(0, 2047));
			send_request(req, 1'b0, '0);
			graphs_done++;
		end

		in_valid <= 1'b0;
		while (pending_counts.size() > 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d requests over %0d random graphs plus the directed table,",
			requests_sent, graphs_done);
		$display("%0d counts checked, vertex count from 0 up to %0d, %0d mismatches",
			counts_seen, largest_n, errors);
		if (errors == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

	// A wedged handshake ends the run here.
	initial begin
		#500_000_000;
		$display("tb failed");
		$finish;
	end

endmodule
